// File: design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg - shared constants for the modular exponentiation block
// Field widths, reset modulus and the digit-serial multiplier length.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int BaseW        = 31;           // base field
  localparam int ExpW         = 32;           // exponent field
  localparam int ModW         = 31;           // modulus and power
  localparam int ExpBitsDflt  = 32;           // exponent bits walked per word
  localparam int InDataW      = 64;           // base + exponent, byte padded
  localparam int OutDataW     = 32;           // power, byte padded
  localparam int MulSteps     = 31;           // one multiplier bit per cycle
  localparam int StepW        = 5;

  localparam logic [ModW-1:0] ModulusReset = 31'd998244353;

  // Reduce t < 3m to t mod m, given m and 2m.
  function automatic logic [ModW-1:0] red3(input logic [ModW+1:0] t,
                                           input logic [ModW+1:0] m1,
                                           input logic [ModW+1:0] m2);
    logic [ModW+1:0] d;
    begin
      if (t >= m2) begin
        d = t - m2;
      end else if (t >= m1) begin
        d = t - m1;
      end else begin
        d = t;
      end
      red3 = d[ModW-1:0];
    end
  endfunction

endpackage

// File: design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation - base^exponent mod modulus, square-and-multiply
// Left-to-right exponent walk over a bit-serial interleaved modular multiplier.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | contents
//  --------+-----------+----------------------+--------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | modulus (31 bits)
//  s_axis  | in        | s_tvalid/s_tready    | base [30:0], exponent [62:31]
//  m_axis  | out       | m_tvalid/m_tready    | power [30:0]
//
//  One word at a time. A word with a nonzero exponent (after keeping the low
//  EXP_BITS bits) and nonzero modulus runs a base reduction, then for each of
//  the EXP_BITS exponent bits a square and, for each set bit, a multiply; the
//  multiplier consumes one bit of its second operand per cycle in each of them.
//  Zero exponent or zero modulus: no multiplier passes, straight to S_FIN.
//  Reset (rst, synchronous) restores modulus 998244353 and empties the block.
//  A result waits in the output register; the next word is taken meanwhile
//  and its result waits in the working register until the output is free.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int EXP_BITS = mexp_pkg::ExpBitsDflt
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write: modulus
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mexp_pkg::ModW-1:0]     cfg_data,
  // input words
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mexp_pkg::InDataW-1:0]  s_tdata,   // base[30:0], exponent[62:31], pad
  // result words
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mexp_pkg::OutDataW-1:0] m_tdata    // power[30:0], pad
);
  import mexp_pkg::*;

  localparam int CntW = $clog2(EXP_BITS + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;   // base mod m
  localparam logic [2:0] S_SQR  = 3'd2;   // r = r*r mod m
  localparam logic [2:0] S_MUL  = 3'd3;   // r = r*b mod m
  localparam logic [2:0] S_FIN  = 3'd4;   // wait for output register

  logic [2:0]          state;
  logic [ModW-1:0]     modulus;

  // exponent walk
  logic [EXP_BITS-1:0] e_sr;
  logic [CntW-1:0]     bits_left;

  // multiplier: acc = (2*acc + ybit*x) mod m, y shifted out msb first
  logic [ModW-1:0]     mx;
  logic [ModW-1:0]     my;
  logic [ModW-1:0]     acc;
  logic [StepW-1:0]    step;

  logic [ModW-1:0]     bred;    // base reduced below m
  logic [ModW-1:0]     r;       // running power / finished result

  logic [ModW-1:0]     power;
  logic                out_valid;

  logic [ModW+1:0]     m1_x;
  logic [ModW+1:0]     m2_x;
  logic [ModW+1:0]     t;
  logic [ModW-1:0]     prod;
  logic                last_step;
  logic                out_free;
  logic                in_acc;

  logic [EXP_BITS+ExpW-1:0] e_wide;
  logic [EXP_BITS-1:0]      e_load;
  logic [BaseW-1:0]         base_in;
  logic [ModW-1:0]          r_init;
  logic [EXP_BITS-1:0]      e_shift;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid & s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(OutDataW-ModW){1'b0}}, power};
  assign out_free  = ~out_valid | m_tready;

  assign base_in = s_tdata[BaseW-1:0];
  assign e_wide  = {{EXP_BITS{1'b0}}, s_tdata[BaseW+ExpW-1:BaseW]};
  assign e_load  = e_wide[EXP_BITS-1:0];   // drop bits at or above EXP_BITS

  // one multiplier bit: t < 3m since acc < m and x <= m
  assign m1_x      = {2'b00, modulus};
  assign m2_x      = {1'b0, modulus, 1'b0};
  assign t         = {1'b0, acc, 1'b0} + (my[ModW-1] ? {2'b00, mx} : '0);
  assign prod      = red3(t, m1_x, m2_x);
  assign last_step = (step == '0);

  assign r_init  = (modulus == ModW'(1)) ? '0 : ModW'(1);
  assign e_shift = e_sr << 1;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ModulusReset;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            e_sr      <= e_load;
            bits_left <= CntW'(EXP_BITS);
            if (e_load == '0) begin
              r     <= ModW'(1);
              state <= S_FIN;
            end else if (modulus == '0) begin
              r     <= '0;
              state <= S_FIN;
            end else begin
              // base mod m computed as 1 * base mod m
              mx    <= ModW'(1);
              my    <= base_in;
              acc   <= '0;
              step  <= StepW'(MulSteps - 1);
              state <= S_RED;
            end
          end
        end
        S_RED, S_SQR, S_MUL: begin
          if (last_step) begin
            acc  <= '0;
            step <= StepW'(MulSteps - 1);
            if (state == S_RED) begin
              bred  <= prod;
              r     <= r_init;
              mx    <= r_init;
              my    <= r_init;
              state <= S_SQR;
            end else if (state == S_SQR && e_sr[EXP_BITS-1]) begin
              r     <= prod;
              mx    <= prod;
              my    <= bred;
              state <= S_MUL;
            end else begin
              // bit done: square alone or square then multiply
              r         <= prod;
              e_sr      <= e_shift;
              bits_left <= bits_left - CntW'(1);
              mx        <= prod;
              my        <= prod;
              if (bits_left == CntW'(1)) begin
                state <= S_FIN;
              end else begin
                state <= S_SQR;
              end
            end
          end else begin
            acc  <= prod;
            my   <= my << 1;
            step <= step - StepW'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            power <= r;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
